[src/dhsw_pkg.sv]
package dhsw_pkg;

  localparam int unsigned BeatW    = 32;
  localparam int unsigned StallW   = 17;
  localparam int unsigned LimitW   = 16;
  localparam int unsigned RestartW = 8;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_STALL_LIMIT   = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_RESTART_LIMIT = 1'b1;

  localparam logic [LimitW-1:0]   STALL_LIMIT_RST   = 16'd10;
  localparam logic [RestartW-1:0] RESTART_LIMIT_RST = 8'd3;

  typedef enum logic [2:0] {
    ST_NORMAL  = 3'd0,
    ST_STALL   = 3'd1,
    ST_NOSTART = 3'd2,
    ST_FAULT   = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_e;

  // per-channel beat check result
  typedef struct packed {
    logic changed;
    logic stall;
  } chk_t;

endpackage

[src/dhsw_chan.sv]
module dhsw_chan (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic [dhsw_pkg::BeatW-1:0]       beat_i,
  input  logic [dhsw_pkg::LimitW-1:0]      stall_limit_i,
  output dhsw_pkg::chk_t                   chk_o
);

  logic [dhsw_pkg::BeatW-1:0]  last_q, last_d;
  logic [dhsw_pkg::StallW-1:0] count_q, count_d;

  assign chk_o.changed = (beat_i != last_q);
  assign chk_o.stall   = !chk_o.changed && (count_q > {1'b0, stall_limit_i});

  always_comb begin
    last_d  = last_q;
    count_d = count_q;
    if (en_i) begin
      if (chk_o.changed) begin
        last_d  = beat_i;
        count_d = '0;
      end else if (chk_o.stall) begin
        count_d = '0;
      end else begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      count_q <= '0;
    end else begin
      last_q  <= last_d;
      count_q <= count_d;
    end
  end

endmodule

[src/dual_heartbeat_stall_watchdog_core.sv]
// Dual heartbeat stall watchdog. Each input word is one watchdog tick carrying
// the system and algorithm heartbeat counters; each tick yields exactly one
// result word with both held channel statuses and the restart / give-up-host
// pulses. A tick is held in the input register and evaluated in a single pass
// into the result register, where the channel state is updated, so the block
// takes one word per clock while the result side does not stall. The result
// register decouples the sides: a new word enters while a finished result waits.
// Configuration (stall_limit at index 0, restart_limit at index 1) is to be written through
// a plain write port while the block is idle; the block itself does not enforce this.
module dual_heartbeat_stall_watchdog_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dhsw_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [dhsw_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              upload_active_i,
  input  logic                              election_done_i,
  input  logic                              sys_source_ok_i,
  input  logic [dhsw_pkg::BeatW-1:0]        sys_beat_i,
  input  logic                              alg_source_ok_i,
  input  logic [dhsw_pkg::BeatW-1:0]        alg_beat_i,
  input  logic                              host_mode_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [2:0]                        sys_status_o,
  output logic [2:0]                        alg_status_o,
  output logic                              restart_sys_o,
  output logic                              restart_alg_o,
  output logic                              give_up_host_o
);

  logic [dhsw_pkg::LimitW-1:0]   stall_limit_q;
  logic [dhsw_pkg::RestartW-1:0] restart_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_limit_q   <= dhsw_pkg::STALL_LIMIT_RST;
      restart_limit_q <= dhsw_pkg::RESTART_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dhsw_pkg::CFG_STALL_LIMIT:   stall_limit_q   <= cfg_wdata_i;
        dhsw_pkg::CFG_RESTART_LIMIT: restart_limit_q <= cfg_wdata_i[dhsw_pkg::RestartW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                       s1_valid_q;
  logic                       upload_q, elected_q, sys_ok_q, alg_ok_q, host_q;
  logic [dhsw_pkg::BeatW-1:0] sys_beat_q, alg_beat_q;
  logic                       in_accept, advance;

  assign advance    = s1_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      upload_q   <= upload_active_i;
      elected_q  <= election_done_i;
      sys_ok_q   <= sys_source_ok_i;
      sys_beat_q <= sys_beat_i;
      alg_ok_q   <= alg_source_ok_i;
      alg_beat_q <= alg_beat_i;
      host_q     <= host_mode_i;
    end
  end

  // evaluation
  dhsw_pkg::chk_t sys_chk, alg_chk;
  logic           eval, sys_en, alg_en, sys_stalled;

  assign eval        = advance && elected_q && !upload_q;
  assign sys_en      = eval && sys_ok_q;
  assign sys_stalled = sys_ok_q && sys_chk.stall;
  assign alg_en      = eval && !sys_stalled && alg_ok_q;

  dhsw_chan u_sys_chan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (sys_en),
    .beat_i        (sys_beat_q),
    .stall_limit_i (stall_limit_q),
    .chk_o         (sys_chk)
  );

  dhsw_chan u_alg_chan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (alg_en),
    .beat_i        (alg_beat_q),
    .stall_limit_i (stall_limit_q),
    .chk_o         (alg_chk)
  );

  dhsw_pkg::status_e             sys_status_q, sys_status_d, alg_status_q, alg_status_d;
  logic [dhsw_pkg::RestartW-1:0] restart_cnt_q, restart_cnt_d, restart_inc;
  logic                          rs_d, ra_d, gh_d;

  assign restart_inc = restart_cnt_q + 1'b1;

  always_comb begin
    sys_status_d  = sys_status_q;
    alg_status_d  = alg_status_q;
    restart_cnt_d = restart_cnt_q;
    rs_d          = 1'b0;
    ra_d          = 1'b0;
    gh_d          = 1'b0;
    if (eval) begin
      if (!sys_ok_q) begin
        sys_status_d = dhsw_pkg::ST_FAULT;
      end else if (sys_chk.changed) begin
        sys_status_d = dhsw_pkg::ST_NORMAL;
      end else if (sys_chk.stall) begin
        rs_d = 1'b1;
        if (restart_inc > restart_limit_q) begin
          // too many restarts: declare cannot-start
          sys_status_d  = dhsw_pkg::ST_NOSTART;
          restart_cnt_d = '0;
          gh_d          = host_q;
        end else begin
          sys_status_d  = dhsw_pkg::ST_STALL;
          restart_cnt_d = restart_inc;
        end
      end
      if (!sys_stalled) begin
        if (!alg_ok_q) begin
          alg_status_d = dhsw_pkg::ST_FAULT;
        end else if (alg_chk.changed) begin
          alg_status_d = dhsw_pkg::ST_NORMAL;
        end else if (alg_chk.stall) begin
          alg_status_d = dhsw_pkg::ST_STALL;
          ra_d         = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_status_q  <= dhsw_pkg::ST_UNKNOWN;
      alg_status_q  <= dhsw_pkg::ST_UNKNOWN;
      restart_cnt_q <= '0;
    end else begin
      sys_status_q  <= sys_status_d;
      alg_status_q  <= alg_status_d;
      restart_cnt_q <= restart_cnt_d;
    end
  end

  // result register
  logic       out_valid_q;
  logic [2:0] out_sys_q, out_alg_q;
  logic       out_rs_q, out_ra_q, out_gh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_sys_q <= sys_status_d;
      out_alg_q <= alg_status_d;
      out_rs_q  <= rs_d;
      out_ra_q  <= ra_d;
      out_gh_q  <= gh_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sys_status_o   = out_sys_q;
  assign alg_status_o   = out_alg_q;
  assign restart_sys_o  = out_rs_q;
  assign restart_alg_o  = out_ra_q;
  assign give_up_host_o = out_gh_q;

  a_restart_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(restart_sys_o && restart_alg_o))
    else $error("both restart pulses in one word");

  a_give_up_nostart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && give_up_host_o |-> restart_sys_o && sys_status_o == dhsw_pkg::ST_NOSTART)
    else $error("give up host without cannot-start");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("evaluated word lost");

  a_restart_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $stable(restart_limit_q) && restart_limit_q != 8'hFF |->
      restart_cnt_q <= restart_limit_q || $past(restart_limit_q) != restart_limit_q
      || restart_cnt_q == $past(restart_cnt_q))
    else $error("restart count grew past limit");

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SweepTicks = 140;

  typedef struct packed {
    logic                       upload;
    logic                       elected;
    logic                       sys_ok;
    logic [dhsw_pkg::BeatW-1:0] sys_beat;
    logic                       alg_ok;
    logic [dhsw_pkg::BeatW-1:0] alg_beat;
    logic                       host;
  } tick_t;

  typedef struct packed {
    dhsw_pkg::status_e sys_st;
    dhsw_pkg::status_e alg_st;
    logic              rs;
    logic              ra;
    logic              gh;
  } verdict_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we;
  logic [dhsw_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [dhsw_pkg::CfgDataW-1:0] cfg_wdata;
  logic                          in_valid;
  logic                          in_stall;
  tick_t                         tick;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [2:0]                    sys_status;
  logic [2:0]                    alg_status;
  logic                          restart_sys;
  logic                          restart_alg;
  logic                          give_up_host;

  // watchdog copy: limits and per-channel state
  logic [dhsw_pkg::LimitW-1:0]   stall_lim = dhsw_pkg::STALL_LIMIT_RST;
  logic [dhsw_pkg::RestartW-1:0] restart_lim = dhsw_pkg::RESTART_LIMIT_RST;
  logic [dhsw_pkg::BeatW-1:0]    sys_last = '0;
  logic [dhsw_pkg::StallW-1:0]   sys_cnt = '0;
  logic [dhsw_pkg::RestartW-1:0] sys_restarts = '0;
  logic [dhsw_pkg::BeatW-1:0]    alg_last = '0;
  logic [dhsw_pkg::StallW-1:0]   alg_cnt = '0;
  dhsw_pkg::status_e             sys_st = dhsw_pkg::ST_UNKNOWN;
  dhsw_pkg::status_e             alg_st = dhsw_pkg::ST_UNKNOWN;

  verdict_t    expected_verdicts[$];
  verdict_t    want;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int          hold_left = 0;
  bit          tx_idle_en = 1'b1;
  bit          rx_idle_en = 1'b1;

  dual_heartbeat_stall_watchdog_core uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .upload_active_i (tick.upload),
    .election_done_i (tick.elected),
    .sys_source_ok_i (tick.sys_ok),
    .sys_beat_i      (tick.sys_beat),
    .alg_source_ok_i (tick.alg_ok),
    .alg_beat_i      (tick.alg_beat),
    .host_mode_i     (tick.host),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .sys_status_o    (sys_status),
    .alg_status_o    (alg_status),
    .restart_sys_o   (restart_sys),
    .restart_alg_o   (restart_alg),
    .give_up_host_o  (give_up_host)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic tick_t tick_of(input logic upload, input logic elected,
                                    input logic sys_ok,
                                    input logic [dhsw_pkg::BeatW-1:0] sys_beat,
                                    input logic alg_ok,
                                    input logic [dhsw_pkg::BeatW-1:0] alg_beat,
                                    input logic host);
    tick_t t;
    t.upload   = upload;
    t.elected  = elected;
    t.sys_ok   = sys_ok;
    t.sys_beat = sys_beat;
    t.alg_ok   = alg_ok;
    t.alg_beat = alg_beat;
    t.host     = host;
    return t;
  endfunction

  // Clear the stall count on a new beat; otherwise advance it and declare a
  // stall, clearing the count, once the count before the increment is above the limit.
  task automatic beat_check(input logic [dhsw_pkg::BeatW-1:0] beat,
                            inout logic [dhsw_pkg::BeatW-1:0] last,
                            inout logic [dhsw_pkg::StallW-1:0] cnt,
                            inout dhsw_pkg::status_e st,
                            output logic stalled);
    logic [dhsw_pkg::StallW-1:0] prior;
    stalled = 1'b0;
    if (beat != last) begin
      last = beat;
      cnt  = '0;
      st   = dhsw_pkg::ST_NORMAL;
    end else begin
      prior = cnt;
      cnt   = prior + 1'b1;
      if (prior > stall_lim) begin
        cnt     = '0;
        st      = dhsw_pkg::ST_STALL;
        stalled = 1'b1;
      end
    end
  endtask

  task automatic predict_tick(input tick_t t, output verdict_t v);
    logic sys_hit;
    logic alg_hit;
    sys_hit = 1'b0;
    v.rs = 1'b0;
    v.ra = 1'b0;
    v.gh = 1'b0;
    if (t.elected && !t.upload) begin
      if (!t.sys_ok) begin
        sys_st = dhsw_pkg::ST_FAULT;
      end else begin
        beat_check(t.sys_beat, sys_last, sys_cnt, sys_st, sys_hit);
        if (sys_hit) begin
          sys_restarts = sys_restarts + 1'b1;
          if (sys_restarts > restart_lim) begin
            v.gh         = t.host;
            sys_st       = dhsw_pkg::ST_NOSTART;
            sys_restarts = '0;
          end
          v.rs = 1'b1;
        end
      end
      // a system stall skips the algorithm channel
      if (!sys_hit) begin
        if (!t.alg_ok) begin
          alg_st = dhsw_pkg::ST_FAULT;
        end else begin
          beat_check(t.alg_beat, alg_last, alg_cnt, alg_st, alg_hit);
          v.ra = alg_hit;
        end
      end
    end
    v.sys_st = sys_st;
    v.alg_st = alg_st;
  endtask

  task automatic send_tick(input tick_t t);
    int unsigned gap;
    verdict_t    v;
    gap = tx_idle_en ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    tick     <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tick(t, v);
    expected_verdicts.push_back(v);
  endtask

  // drop valid and drain every pending result
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [dhsw_pkg::CfgIdxW-1:0] idx,
                           input logic [dhsw_pkg::CfgDataW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == dhsw_pkg::CFG_STALL_LIMIT) stall_lim = value;
    else restart_lim = value[dhsw_pkg::RestartW-1:0];
  endtask

  task automatic apply_limits(input logic [dhsw_pkg::LimitW-1:0] stall,
                              input logic [dhsw_pkg::RestartW-1:0] restart);
    settle();
    write_cfg(dhsw_pkg::CFG_STALL_LIMIT, stall);
    write_cfg(dhsw_pkg::CFG_RESTART_LIMIT, dhsw_pkg::CfgDataW'(restart));
  endtask

  task automatic check_field(input string name, input logic [2:0] exp_val,
                             input logic [2:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      errors++;
    end
  endtask

  // check each word taken from the result side and redraw the receiver stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        $error("result word with no tick pending");
        errors++;
      end else begin
        want = expected_verdicts.pop_front();
        check_field("sys_status", want.sys_st, sys_status);
        check_field("alg_status", want.alg_st, alg_status);
        check_field("restart_sys", {2'b00, want.rs}, {2'b00, restart_sys});
        check_field("restart_alg", {2'b00, want.ra}, {2'b00, restart_alg});
        check_field("give_up_host", {2'b00, want.gh}, {2'b00, give_up_host});
      end
      hold_left = rx_idle_en ? $urandom_range(0, 19) : 0;
      out_stall <= (hold_left != 0);
    end else if (out_stall) begin
      hold_left = hold_left - 1;
      out_stall <= (hold_left > 0);
    end
  end

  // gating, source faults and extreme beats under the reset limits
  task automatic test_hold_and_faults();
    send_tick(tick_of(1'b0, 1'b0, 1'b1, 32'h1, 1'b1, 32'h1, 1'b0));
    send_tick(tick_of(1'b1, 1'b1, 1'b1, 32'h2, 1'b1, 32'h2, 1'b1));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 32'h0, 1'b1, 32'h0, 1'b0));
    send_tick(tick_of(1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b1));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b0));
    send_tick(tick_of(1'b1, 1'b0, 1'b0, 32'h5A5A_A5A5, 1'b0, 32'hA5A5_5A5A, 1'b1));
  endtask

  // lowest limits: stalls, cannot-start with and without host, algorithm stall
  task automatic test_stall_restart();
    apply_limits('0, '0);
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 32'h7, 1'b1, 32'h9, 1'b1));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 32'h7, 1'b1, 32'h9, 1'b1));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 32'h7, 1'b1, 32'h9, 1'b1));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 32'h7, 1'b1, 32'h9, 1'b0));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 32'h7, 1'b1, 32'h9, 1'b0));
    apply_limits('0, 8'd1);
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 32'h7, 1'b1, 32'h9, 1'b1));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 32'h7, 1'b1, 32'h9, 1'b1));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 32'h8, 1'b1, 32'h9, 1'b1));
    send_tick(tick_of(1'b0, 1'b1, 1'b1, 32'h9, 1'b1, 32'h9, 1'b1));
  endtask

  // build a count under the top limit, then lower it: the next repeat stalls at once
  task automatic test_lowered_limit();
    apply_limits(16'hFFFF, 8'hFF);
    repeat (5) send_tick(tick_of(1'b0, 1'b1, 1'b1, 32'h3, 1'b1, 32'h4, 1'b1));
    apply_limits(16'd1, 8'hFF);
    repeat (3) send_tick(tick_of(1'b0, 1'b1, 1'b1, 32'h3, 1'b1, 32'h4, 1'b1));
  endtask

  task automatic test_random_sweep();
    tick_t       t;
    int unsigned run_len;
    for (int ph = 0; ph < 6; ph++) begin
      unique case (ph)
        0: apply_limits('0, '0);
        1: apply_limits(16'd1, 8'd1);
        2: apply_limits(16'd2, 8'd3);
        3: apply_limits(16'd5, 8'd254);
        4: apply_limits(16'hFFFF, 8'hFF);
        default: apply_limits(16'($urandom_range(0, 6)), 8'($urandom_range(0, 254)));
      endcase
      // hold a beat long enough to reach the stall limit most of the time
      run_len = 3 + 2 * ((stall_lim > 8) ? 8 : stall_lim);
      for (int n = 0; n < SweepTicks; n++) begin
        if (n % 35 == 0) begin
          tx_idle_en = ($urandom_range(0, 3) != 0);
          rx_idle_en = ($urandom_range(0, 3) != 0);
        end
        t.upload   = ($urandom_range(0, 15) == 0);
        t.elected  = ($urandom_range(0, 15) != 0);
        t.sys_ok   = ($urandom_range(0, 19) != 0);
        t.sys_beat = ($urandom_range(0, run_len) == 0) ? $urandom : sys_last;
        t.alg_ok   = ($urandom_range(0, 19) != 0);
        t.alg_beat = ($urandom_range(0, run_len) == 0) ? $urandom : alg_last;
        t.host     = ($urandom_range(0, 1) != 0);
        send_tick(t);
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= dhsw_pkg::CFG_STALL_LIMIT;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    tick      <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_hold_and_faults();
    test_stall_restart();
    test_lowered_limit();
    test_random_sweep();
    settle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
src/dhsw_pkg.sv
src/dhsw_chan.sv
src/dual_heartbeat_stall_watchdog_core.sv
sim/testbench.sv
